// ----- design/csrc_pkg.sv -----
// Shared types and constants for the code set range coalescer.
package csrc_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_QUERY  = 3'd2,
        OP_EMIT   = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic clear_all;
    } store_ctrl_t;

    localparam logic REG_DEVICE_CLASS    = 1'b0;
    localparam logic REG_DELIVERED_CLASS = 1'b1;

    localparam int CLASS_W = 4;
    localparam int CODE_W  = 7;

    localparam logic [CLASS_W-1:0] DEVICE_CLASS_RESET    = 4'd8;
    localparam logic [CLASS_W-1:0] DELIVERED_CLASS_RESET = 4'd0;

    localparam logic [CODE_W-1:0] AUTO_CODE_LO = 7'd2;
    localparam logic [CODE_W-1:0] AUTO_CODE_HI = 7'd6;

    localparam int MAX_RESULTS = 64;
    localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

endpackage

// ----- design/csrc_bitmap_store.sv -----
// Class bitmap memory with per-row valid bits and a registered read port.
module csrc_bitmap_store
    import csrc_pkg::*;
#(
    parameter int NUM_CLASSES = 16,
    parameter int CODE_COUNT  = 128,
    localparam int CW = $clog2(NUM_CLASSES)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  store_ctrl_t           ctrl,
    input  logic [CW-1:0]         addr,
    input  logic [CODE_COUNT-1:0] wr_data,
    output logic [CODE_COUNT-1:0] rd_row
);

    logic [CODE_COUNT-1:0]  mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] row_valid_reg;
    logic [CODE_COUNT-1:0]  rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg  <= mem[addr];
        rd_valid_reg <= row_valid_reg[addr];
    end

    // A row that has not been written since reset or the last clear reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ctrl.clear_all) begin
            row_valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            row_valid_reg[addr] <= 1'b1;
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- design/code_set_range_coalescer.sv -----
// Top level of the code set range coalescer: control, run scanner and output register.
//
//   channel  direction  handshake             payload
//   s_       in         s_valid / s_ready     s_opcode, s_class_index, s_auto_classify, s_code
//   m_       out        m_valid / m_ready     m_present, m_run_valid, m_run_first, m_run_last,
//                                             m_last_of_run_list, m_recording_active
//   cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Add, remove, query, clear and unused opcodes pass through accept, memory read, and
// modify with write back. Emit passes through accept and memory read, then the scanner
// steps through up to CODE_COUNT codes one bit a cycle, holding at a run end while stalled.
// Reset clears the row valid bits and the active flag and sets the class registers to their reset values.
// A stalled output holds the scanner or the write back until the result is taken.
module code_set_range_coalescer
    import csrc_pkg::*;
#(
    parameter int NUM_CLASSES = 16,
    parameter int CODE_COUNT  = 128
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [CLASS_W-1:0] s_class_index,
    input  logic               s_auto_classify,
    input  logic [CODE_W-1:0]  s_code,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_present,
    output logic               m_run_valid,
    output logic [CODE_W-1:0]  m_run_first,
    output logic [CODE_W-1:0]  m_run_last,
    output logic               m_last_of_run_list,
    output logic               m_recording_active,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [CLASS_W-1:0] cfg_data
);

    localparam int CW = $clog2(NUM_CLASSES);
    localparam int BW = $clog2(CODE_COUNT);

    state_t state_reg, state_next;

    logic [CLASS_W-1:0] device_class_reg, delivered_class_reg;
    logic               active_reg, active_next;

    logic [2:0]         op_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [CLASS_W-1:0] eff_class;

    logic [CODE_COUNT-1:0]   scan_reg, scan_next;
    logic [BW-1:0]           idx_reg, idx_next;
    logic [BW-1:0]           first_reg, first_next;
    logic                    in_run_reg, in_run_next;
    logic [RESULT_CNT_W-1:0] n_reg, n_next;

    logic              m_valid_reg;
    logic              present_reg, present_next;
    logic              run_valid_reg, run_valid_next;
    logic [CODE_W-1:0] run_first_reg, run_first_next;
    logic [CODE_W-1:0] run_last_reg, run_last_next;
    logic              fin_reg, fin_next;
    logic              act_out_reg;
    logic              out_load;
    logic              out_free;

    store_ctrl_t           store_ctrl;
    logic [CODE_COUNT-1:0] wr_data;
    logic [CODE_COUNT-1:0] rd_row;
    logic [CODE_COUNT-1:0] row;
    logic [CODE_COUNT-1:0] bit_mask;

    logic [CW+CLASS_W-1:0] cls_ext;
    logic [CW-1:0]         row_addr;
    logic                  cls_ok;
    logic [BW+CODE_W-1:0]  code_ext;
    logic                  code_ok;
    logic [BW+CODE_W-1:0]  run_first_ext, run_last_ext;
    logic [BW-1:0]         run_start;
    logic                  run_end;
    logic                  more_after;
    logic                  s_fire;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        eff_class = s_class_index;
        if ((s_opcode == OP_ADD) && s_auto_classify) begin
            eff_class = ((s_code >= AUTO_CODE_LO) && (s_code <= AUTO_CODE_HI))
                        ? device_class_reg : delivered_class_reg;
        end
    end

    assign cls_ext  = (CW + CLASS_W)'(cls_reg);
    assign cls_ok   = cls_ext < (CW + CLASS_W)'(NUM_CLASSES);
    assign row_addr = cls_ext[CW-1:0];
    assign code_ext = (BW + CODE_W)'(code_reg);
    assign code_ok  = code_ext < (BW + CODE_W)'(CODE_COUNT);
    assign bit_mask = code_ok ? (CODE_COUNT'(1) << code_ext[BW-1:0]) : '0;
    assign row      = cls_ok ? rd_row : '0;

    assign run_end       = scan_reg[0] && !scan_reg[1];
    assign more_after    = |scan_reg[CODE_COUNT-1:1];
    assign run_start     = in_run_reg ? first_reg : idx_reg;
    assign run_first_ext = (BW + CODE_W)'(run_start);
    assign run_last_ext  = (BW + CODE_W)'(idx_reg);

    csrc_bitmap_store #(
        .NUM_CLASSES (NUM_CLASSES),
        .CODE_COUNT  (CODE_COUNT)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (store_ctrl),
        .addr    (row_addr),
        .wr_data (wr_data),
        .rd_row  (rd_row)
    );

    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        scan_next       = scan_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        in_run_next     = in_run_reg;
        n_next          = n_reg;
        store_ctrl      = '0;
        wr_data         = row;
        out_load        = 1'b0;
        present_next    = 1'b0;
        run_valid_next  = 1'b0;
        run_first_next  = '0;
        run_last_next   = '0;
        fin_next        = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if ((op_reg == OP_EMIT) && (row != '0)) begin
                    scan_next   = row;
                    idx_next    = '0;
                    in_run_next = 1'b0;
                    n_next      = '0;
                    state_next  = ST_SCAN;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_ADD: begin
                            active_next      = 1'b1;
                            wr_data          = row | bit_mask;
                            store_ctrl.wr_en = cls_ok && code_ok;
                        end
                        OP_REMOVE: begin
                            wr_data          = row & ~bit_mask;
                            store_ctrl.wr_en = cls_ok && code_ok;
                        end
                        OP_QUERY: begin
                            present_next = (row & bit_mask) != '0;
                        end
                        OP_CLEAR: begin
                            store_ctrl.clear_all = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (run_end) begin
                    if (out_free) begin
                        out_load       = 1'b1;
                        run_valid_next = 1'b1;
                        run_first_next = run_first_ext[CODE_W-1:0];
                        run_last_next  = run_last_ext[CODE_W-1:0];
                        fin_next       = !more_after
                                         || (n_reg == RESULT_CNT_W'(MAX_RESULTS - 1));
                        n_next         = n_reg + 1'b1;
                        in_run_next    = 1'b0;
                        scan_next      = scan_reg >> 1;
                        idx_next       = idx_reg + 1'b1;
                        if (fin_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    if (scan_reg[0] && !in_run_reg) begin
                        first_next = idx_reg;
                    end
                    in_run_next = scan_reg[0];
                    scan_next   = scan_reg >> 1;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            active_reg          <= 1'b0;
            device_class_reg    <= DEVICE_CLASS_RESET;
            delivered_class_reg <= DELIVERED_CLASS_RESET;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DEVICE_CLASS:    device_class_reg    <= cfg_data;
                    REG_DELIVERED_CLASS: delivered_class_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_opcode;
            cls_reg  <= eff_class;
            code_reg <= s_code;
        end
        scan_reg   <= scan_next;
        idx_reg    <= idx_next;
        first_reg  <= first_next;
        in_run_reg <= in_run_next;
        n_reg      <= n_next;
        if (out_load) begin
            present_reg   <= present_next;
            run_valid_reg <= run_valid_next;
            run_first_reg <= run_first_next;
            run_last_reg  <= run_last_next;
            fin_reg       <= fin_next;
            act_out_reg   <= active_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_present          = present_reg;
    assign m_run_valid        = run_valid_reg;
    assign m_run_first        = run_first_reg;
    assign m_run_last         = run_last_reg;
    assign m_last_of_run_list = fin_reg;
    assign m_recording_active = act_out_reg;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the code set range coalescer, built around a per-class bitmap model.
module tb;
    import csrc_pkg::*;

    localparam int NUM_CLASSES  = 16;
    localparam int CODE_COUNT   = 128;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 140;

    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic              present;
        logic              run_valid;
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] last;
        logic              fin;
        logic              active;
    } code_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [2:0]         s_opcode        = OP_ADD;
    logic [CLASS_W-1:0] s_class_index   = '0;
    logic               s_auto_classify = 1'b0;
    logic [CODE_W-1:0]  s_code          = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_present;
    logic               m_run_valid;
    logic [CODE_W-1:0]  m_run_first;
    logic [CODE_W-1:0]  m_run_last;
    logic               m_last_of_run_list;
    logic               m_recording_active;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = REG_DEVICE_CLASS;
    logic [CLASS_W-1:0] cfg_data  = '0;

    logic [CODE_COUNT-1:0] model_rows [NUM_CLASSES];
    logic                  model_active;
    logic [CLASS_W-1:0]    model_dev_class;
    logic [CLASS_W-1:0]    model_dlv_class;
    code_result_t          awaited_results [$];

    int error_count     = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int ready_hold      = 0;
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;

    code_set_range_coalescer #(
        .NUM_CLASSES(NUM_CLASSES),
        .CODE_COUNT (CODE_COUNT)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_class_index     (s_class_index),
        .s_auto_classify   (s_auto_classify),
        .s_code            (s_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_present         (m_present),
        .m_run_valid       (m_run_valid),
        .m_run_first       (m_run_first),
        .m_run_last        (m_run_last),
        .m_last_of_run_list(m_last_of_run_list),
        .m_recording_active(m_recording_active),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (receiver_stalls && $urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 16);
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 16);
        end
    end

    always @(posedge aclk) begin
        code_result_t exp_rec;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("Result transaction arrived with no expectation pending.");
                error_count++;
            end else begin
                exp_rec = awaited_results.pop_front();
                if (m_present !== exp_rec.present) begin
                    $error("m_present: expected %0d, got %0d", exp_rec.present, m_present);
                    error_count++;
                end
                if (m_run_valid !== exp_rec.run_valid) begin
                    $error("m_run_valid: expected %0d, got %0d", exp_rec.run_valid, m_run_valid);
                    error_count++;
                end
                if (m_run_first !== exp_rec.first) begin
                    $error("m_run_first: expected %0d, got %0d", exp_rec.first, m_run_first);
                    error_count++;
                end
                if (m_run_last !== exp_rec.last) begin
                    $error("m_run_last: expected %0d, got %0d", exp_rec.last, m_run_last);
                    error_count++;
                end
                if (m_last_of_run_list !== exp_rec.fin) begin
                    $error("m_last_of_run_list: expected %0d, got %0d", exp_rec.fin,
                           m_last_of_run_list);
                    error_count++;
                end
                if (m_recording_active !== exp_rec.active) begin
                    $error("m_recording_active: expected %0d, got %0d", exp_rec.active,
                           m_recording_active);
                    error_count++;
                end
            end
        end
    end

    // Updates the class bitmaps and queues the results that one transaction must produce.
    function automatic void apply_code_op(input logic [2:0] op, input logic [CLASS_W-1:0] cls,
                                          input logic autoc, input logic [CODE_W-1:0] code);
        code_result_t       rec;
        code_result_t       run;
        logic [CLASS_W-1:0] target;
        int                 c;
        int                 first;
        int                 n;
        int                 k;
        rec     = '0;
        rec.fin = 1'b1;
        run     = '0;
        target  = cls;
        n       = 0;
        c       = 0;
        case (op)
            OP_ADD: begin
                model_active = 1'b1;
                if (autoc) begin
                    target = (code >= AUTO_CODE_LO && code <= AUTO_CODE_HI) ?
                             model_dev_class : model_dlv_class;
                end
                model_rows[target][code] = 1'b1;
            end
            OP_REMOVE: model_rows[cls][code] = 1'b0;
            OP_QUERY:  rec.present = model_rows[cls][code];
            OP_CLEAR: begin
                for (k = 0; k < NUM_CLASSES; k++) model_rows[k] = '0;
            end
            OP_EMIT: begin
                run.run_valid = 1'b1;
                run.active    = model_active;
                while (c < CODE_COUNT && n < MAX_RESULTS) begin
                    if (model_rows[cls][c]) begin
                        first = c;
                        while (c + 1 < CODE_COUNT && model_rows[cls][c + 1]) c++;
                        run.first = CODE_W'(first);
                        run.last  = CODE_W'(c);
                        awaited_results.push_back(run);
                        n++;
                    end
                    c++;
                end
            end
            default: ;
        endcase
        if (n > 0) begin
            run     = awaited_results.pop_back();
            run.fin = 1'b1;
            awaited_results.push_back(run);
        end else begin
            rec.active = model_active;
            awaited_results.push_back(rec);
        end
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [CLASS_W-1:0] cls,
                             input logic autoc, input logic [CODE_W-1:0] code);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_class_index   <= cls;
        s_auto_classify <= autoc;
        s_code          <= code;
        do @(posedge aclk); while (!s_ready);
        apply_code_op(op, cls, autoc, code);
        items_sent++;
    endtask

    task automatic settle(input int extra);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_class_regs(input logic [CLASS_W-1:0] dev, input logic [CLASS_W-1:0] dlv);
        settle(8);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DEVICE_CLASS;
        cfg_data  <= dev;
        do @(posedge aclk); while (!cfg_ready);
        model_dev_class = dev;
        cfg_index <= REG_DELIVERED_CLASS;
        cfg_data  <= dlv;
        do @(posedge aclk); while (!cfg_ready);
        model_dlv_class = dlv;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_item(OP_QUERY, 4'd0, 1'b0, 7'd0);
        send_item(OP_EMIT, 4'd15, 1'b0, 7'd0);
        send_item(OP_UNUSED_5, 4'd15, 1'b1, 7'd127);
        send_item(OP_REMOVE, 4'd3, 1'b0, 7'd5);
        send_item(OP_ADD, 4'd0, 1'b0, 7'd0);
        send_item(OP_ADD, 4'd0, 1'b0, 7'd127);
        send_item(OP_ADD, 4'd0, 1'b0, 7'd127);
        send_item(OP_ADD, 4'd0, 1'b0, 7'd1);
        send_item(OP_QUERY, 4'd0, 1'b0, 7'd127);
        send_item(OP_QUERY, 4'd0, 1'b0, 7'd126);
        send_item(OP_EMIT, 4'd0, 1'b0, 7'd0);
        send_item(OP_ADD, 4'd5, 1'b1, 7'd2);
        send_item(OP_ADD, 4'd5, 1'b1, 7'd6);
        send_item(OP_ADD, 4'd5, 1'b1, 7'd1);
        send_item(OP_ADD, 4'd5, 1'b1, 7'd7);
        send_item(OP_EMIT, 4'd8, 1'b0, 7'd0);
        send_item(OP_REMOVE, 4'd0, 1'b1, 7'd127);
        send_item(OP_EMIT, 4'd0, 1'b1, 7'd0);
        send_item(OP_UNUSED_6, 4'd0, 1'b0, 7'd1);
        send_item(OP_UNUSED_7, 4'd8, 1'b1, 7'd2);
        send_item(OP_CLEAR, 4'd0, 1'b0, 7'd0);
        send_item(OP_EMIT, 4'd0, 1'b0, 7'd0);
        send_item(OP_QUERY, 4'd8, 1'b1, 7'd2);
    endtask

    task automatic test_class_registers();
        logic [CLASS_W-1:0] dev_list [4];
        logic [CLASS_W-1:0] dlv_list [4];
        int                 i;
        dev_list = '{4'd15, 4'd0, 4'd5, 4'd8};
        dlv_list = '{4'd0, 4'd15, 4'd5, 4'd0};
        for (i = 0; i < 4; i++) begin
            set_class_regs(dev_list[i], dlv_list[i]);
            send_item(OP_ADD, CLASS_W'($urandom_range(0, 15)), 1'b1, 7'd1);
            send_item(OP_ADD, CLASS_W'($urandom_range(0, 15)), 1'b1, 7'd2);
            send_item(OP_ADD, CLASS_W'($urandom_range(0, 15)), 1'b1, 7'd6);
            send_item(OP_ADD, CLASS_W'($urandom_range(0, 15)), 1'b1, 7'd7);
            send_item(OP_ADD, CLASS_W'($urandom_range(0, 15)), 1'b1, 7'd127);
            send_item(OP_EMIT, dev_list[i], 1'b0, 7'd0);
            send_item(OP_EMIT, dlv_list[i], 1'b0, 7'd0);
            send_item(OP_CLEAR, 4'd0, 1'b0, 7'd0);
        end
    endtask

    task automatic test_max_runs();
        int c;
        send_item(OP_CLEAR, 4'd0, 1'b0, 7'd0);
        for (c = 0; c < CODE_COUNT; c += 2) send_item(OP_ADD, 4'd12, 1'b0, CODE_W'(c));
        send_item(OP_EMIT, 4'd12, 1'b0, 7'd0);
        for (c = 1; c < CODE_COUNT; c += 2) send_item(OP_ADD, 4'd12, 1'b0, CODE_W'(c));
        send_item(OP_EMIT, 4'd12, 1'b0, 7'd0);
        send_item(OP_CLEAR, 4'd0, 1'b0, 7'd0);
    endtask

    task automatic test_random();
        int                 phase;
        int                 target;
        int                 sel;
        int                 pick;
        int                 len;
        int                 j;
        logic [2:0]         op;
        logic [CLASS_W-1:0] hot;
        logic [CLASS_W-1:0] cls;
        logic [CODE_W-1:0]  base;
        logic [CODE_W-1:0]  code;
        logic               autoc;
        for (phase = 0; phase < 4; phase++) begin
            set_class_regs(CLASS_W'($urandom_range(0, 15)), CLASS_W'($urandom_range(0, 15)));
            if (phase == 3) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            hot    = CLASS_W'($urandom_range(0, 15));
            base   = CODE_W'($urandom_range(0, 127));
            target = items_sent + 8;
            while (items_sent < target) begin
                sel  = $urandom_range(0, 99);
                pick = $urandom_range(0, 19);
                if (pick < 10) cls = hot;
                else if (pick < 13) cls = model_dev_class;
                else if (pick < 16) cls = model_dlv_class;
                else cls = CLASS_W'($urandom_range(0, 15));
                if ($urandom_range(0, 4) < 3) code = CODE_W'(base + $urandom_range(0, 23));
                else code = CODE_W'($urandom_range(0, 127));
                autoc = ($urandom_range(0, 3) == 0);
                if (sel < 30) begin
                    len = $urandom_range(1, 6);
                    for (j = 0; j < len; j++) send_item(OP_ADD, cls, autoc, CODE_W'(code + j));
                end else if (sel < 45) begin
                    send_item(OP_REMOVE, cls, autoc, code);
                end else if (sel < 65) begin
                    send_item(OP_QUERY, cls, autoc, code);
                end else if (sel < 82) begin
                    send_item(OP_EMIT, cls, autoc, code);
                end else if (sel < 84) begin
                    send_item(OP_CLEAR, cls, autoc, code);
                end else if (sel < 90) begin
                    op = 3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
                    send_item(op, cls, autoc, code);
                end else begin
                    send_item(OP_ADD, cls, autoc, code);
                end
            end
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < NUM_CLASSES; k++) model_rows[k] = '0;
        model_active    = 1'b0;
        model_dev_class = DEVICE_CLASS_RESET;
        model_dlv_class = DELIVERED_CLASS_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_class_registers();
        test_max_runs();
        test_random();
        settle(DRAIN_CYCLES);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/csrc_pkg.sv
design/csrc_bitmap_store.sv
design/code_set_range_coalescer.sv
bench/tb.sv
